// ----- sv/mtg_pkg.sv -----
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int IDX_W        = $clog2(STATE_WORDS);
    localparam int WORD_W       = 32;
    localparam int WRAP_OFFSET  = STATE_WORDS - SHIFT_OFFSET;

    localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0]  FAR_STEP     = IDX_W'(SHIFT_OFFSET);
    localparam logic [IDX_W-1:0]  FAR_WRAP     = IDX_W'(WRAP_OFFSET);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    typedef enum logic [1:0] {
        ST_BOOT,
        ST_SEED,
        ST_RUN
    } mtg_state_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } mtg_push_t;

    function automatic logic [WORD_W-1:0] seed_step(
        input logic [WORD_W-1:0] prev,
        input logic [IDX_W-1:0]  idx
    );
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] p;
        x = prev ^ (prev >> 30);
        p = x * SEED_MULT;
        return p + WORD_W'(idx);
    endfunction

    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] far
    );
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        v = far ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y);
        logic [WORD_W-1:0] t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

// ----- sv/mtg_state_ram.sv -----
`timescale 1ns / 1ps

module mtg_state_ram #(
    parameter int DEPTH = 624,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/mtg_out_buf.sv -----
`timescale 1ns / 1ps

module mtg_out_buf (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mtg_pkg::mtg_push_t        push,
    output logic                      space,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mtg_pkg::WORD_W-1:0] random_word
);

    import mtg_pkg::*;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] out_word_next;
    logic [WORD_W-1:0] skid_word_reg;
    logic [WORD_W-1:0] skid_word_next;
    logic              pop;

    assign pop         = out_valid_reg && out_ready;
    assign space       = !skid_valid_reg;
    assign out_valid   = out_valid_reg;
    assign random_word = out_word_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push.valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_word_next  = push.word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = push.word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");
`endif

endmodule

// ----- sv/mtg_core.sv -----
`timescale 1ns / 1ps

module mtg_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [mtg_pkg::WORD_W-1:0] seed_value,
    input  logic                       space,
    output mtg_pkg::mtg_push_t         push,
    output logic                       ram_we,
    output logic [mtg_pkg::IDX_W-1:0]  ram_waddr,
    output logic [mtg_pkg::WORD_W-1:0] ram_wdata,
    output logic [mtg_pkg::IDX_W-1:0]  ram_raddr_a,
    output logic [mtg_pkg::IDX_W-1:0]  ram_raddr_b,
    input  logic [mtg_pkg::WORD_W-1:0] ram_rdata_a,
    input  logic [mtg_pkg::WORD_W-1:0] ram_rdata_b
);

    import mtg_pkg::*;

    mtg_state_t        state_reg;
    mtg_state_t        state_next;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;
    logic [IDX_W-1:0]  seed_idx_reg;
    logic [IDX_W-1:0]  seed_idx_next;
    logic [WORD_W-1:0] prev_reg;
    logic [WORD_W-1:0] prev_next;
    logic [WORD_W-1:0] cur_reg;
    logic [WORD_W-1:0] cur_next;

    logic              accept;
    logic              draw;
    logic              seed_go;
    logic [WORD_W-1:0] seed_src;
    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] twisted;

    assign seed_word = seed_step(prev_reg, seed_idx_reg);
    assign twisted   = twist_word(cur_reg, ram_rdata_a, ram_rdata_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BOOT:
            begin
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                if (seed_idx_reg == LAST_IDX)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept && cmd == CMD_SEED)
                begin
                    state_next = ST_SEED;
                end
            end
            default:
            begin
                state_next = ST_BOOT;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        seed_go    = 1'b0;
        seed_src   = seed_value;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = seed_word;
        push.valid = 1'b0;
        push.word  = temper(twisted);
        case (state_reg)
            ST_BOOT:
            begin
                seed_go  = 1'b1;
                seed_src = DEFAULT_SEED;
            end
            ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_waddr = seed_idx_reg;
            end
            ST_RUN:
            begin
                in_ready = space;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        accept = in_valid && in_ready;
        draw   = accept && cmd == CMD_DRAW;
        if (accept && cmd == CMD_SEED)
        begin
            seed_go = 1'b1;
        end
        if (seed_go)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = seed_src;
        end
        else if (draw)
        begin
            ram_we     = 1'b1;
            ram_waddr  = ptr_reg;
            ram_wdata  = twisted;
            push.valid = 1'b1;
        end
    end

    always_comb
    begin
        ptr_next      = ptr_reg;
        seed_idx_next = seed_idx_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        if (seed_go)
        begin
            ptr_next      = '0;
            seed_idx_next = IDX_W'(1);
            prev_next     = seed_src;
            cur_next      = seed_src;
        end
        else if (state_reg == ST_SEED)
        begin
            seed_idx_next = seed_idx_reg + IDX_W'(1);
            prev_next     = seed_word;
        end
        else if (draw)
        begin
            ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);
            cur_next = ram_rdata_a;
        end
        ram_raddr_a = (ptr_next == LAST_IDX) ? '0 : ptr_next + IDX_W'(1);
        ram_raddr_b = (ptr_next < FAR_WRAP) ? ptr_next + FAR_STEP : ptr_next - FAR_WRAP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_BOOT;
            ptr_reg      <= '0;
            seed_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            seed_idx_reg <= seed_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
    end

`ifndef ASSERT_OFF
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= LAST_IDX)
        else $error("twist pointer out of range");

    a_draw_advances: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |=> ptr_reg == (($past(ptr_reg) == LAST_IDX) ? '0
                                   : $past(ptr_reg) + IDX_W'(1)))
        else $error("draw did not advance twist pointer");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEED && seed_idx_reg == LAST_IDX)
        |=> (state_reg == ST_RUN && ptr_reg == '0))
        else $error("seed fill did not end at pointer zero");
`endif

endmodule

// ----- sv/mersenne_twister_generator.sv -----
`timescale 1ns / 1ps

// MT19937 32-bit pseudo-random generator.
// Input channel (in_valid/in_ready): cmd = 0 draws the next word, cmd = 1
// reseeds with seed_value. A seed transaction produces no output.
// Output channel (out_valid/out_ready): one random_word per draw, in order.
// Latency: a draw's word is registered in the output buffer the cycle after
// its transaction. Throughput: one draw per cycle while the output buffer
// has space; each draw twists one state word in RAM, reading entries k+1
// and k+397 on the two RAM read ports. Seeding fills the 624-word RAM one
// word per cycle through the seed multiplier: after a seed transaction
// in_ready stays low until the fill is done. Reset: the block seeds itself
// with 5489, so in_ready rises once that fill is done; a draw with no
// prior seed uses that sequence. Receiver stall: a two-entry output buffer
// absorbs one more draw, then in_ready drops until out_ready takes a word.
module mersenne_twister_generator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       cmd,
    input  logic [mtg_pkg::WORD_W-1:0] seed_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mtg_pkg::WORD_W-1:0] random_word
);

    import mtg_pkg::*;

    mtg_push_t         push;
    logic              space;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr_a;
    logic [IDX_W-1:0]  ram_raddr_b;
    logic [WORD_W-1:0] ram_rdata_a;
    logic [WORD_W-1:0] ram_rdata_b;

    mtg_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .seed_value  (seed_value),
        .space       (space),
        .push        (push),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

    mtg_state_ram #(
        .DEPTH (STATE_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    mtg_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .space       (space),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mtg_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int QUIET_TAIL  = 150;
    localparam int SETTLE      = 20;

    typedef struct {
        logic              op;
        logic [WORD_W-1:0] seed;
        bit                drain_first;
    } mt_request_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              cmd = CMD_DRAW;
    logic [WORD_W-1:0] seed_value = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [WORD_W-1:0] random_word;

    mt_request_t       pending_reqs[$];
    logic [WORD_W-1:0] expected_words[$];
    logic [WORD_W-1:0] mt_words[0:STATE_WORDS-1];
    int unsigned       mt_pos;
    int                failures = 0;
    int                send_gap = 0;
    int                sink_gap = 0;
    int                idle_cycles = 0;
    logic              quiet = 1'b0;

    mersenne_twister_generator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .seed_value  (seed_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic mt_fill(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] p;
        mt_words[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = SEED_MULT * (p ^ (p >> 30)) + WORD_W'(i);
        end
        mt_pos = STATE_WORDS;
    endtask

    task automatic mt_twist();
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            y = (mt_words[k] & HIGH_BIT) | (mt_words[(k + 1) % STATE_WORDS] & LOW_BITS);
            v = mt_words[(k + SHIFT_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
            begin
                v = v ^ TWIST_MATRIX;
            end
            mt_words[k] = v;
        end
        mt_pos = 0;
    endtask

    function automatic logic [WORD_W-1:0] mt_temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t ^ (t >> 18);
    endfunction

    task automatic mt_apply(input logic op, input logic [WORD_W-1:0] seed);
        if (op == CMD_SEED)
        begin
            mt_fill(seed);
        end
        else
        begin
            if (mt_pos >= STATE_WORDS)
            begin
                if (mt_pos == STATE_WORDS + 1)
                begin
                    mt_fill(DEFAULT_SEED);
                end
                mt_twist();
            end
            expected_words.push_back(mt_temper(mt_words[mt_pos]));
            mt_pos++;
        end
    endtask

    task automatic add_req(input logic op, input logic [WORD_W-1:0] seed,
                           input bit drain_first);
        mt_request_t r;
        r.op = op;
        r.seed = seed;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        mt_request_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_DRAW;
            seed_value <= '0;
            send_gap <= 0;
            quiet <= 1'b0;
            mt_pos = STATE_WORDS + 1;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                mt_apply(cmd, seed_value);
            end
            quiet <= (pending_reqs.size() < QUIET_TAIL);
            if (!(in_valid && !in_ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 &&
                         !(pending_reqs[0].drain_first && expected_words.size() != 0))
                begin
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    cmd <= r.op;
                    seed_value <= r.seed;
                    if (!quiet && $urandom_range(0, 5) == 0)
                    begin
                        send_gap <= $urandom_range(1, 11);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : sink_proc
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("random_word unexpected transaction: actual %08h", random_word);
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (random_word !== want)
                    begin
                        $error("random_word mismatch: expected %08h actual %08h",
                               want, random_word);
                        failures++;
                    end
                end
            end
            if (sink_gap != 0)
            begin
                sink_gap <= sink_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap <= $urandom_range(0, 10);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        // draws before any seed fall back to the default seed
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_DRAW, 32'hffff_ffff, 1'b0);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_DRAW, 32'hffff_ffff, 1'b0);
        add_req(CMD_SEED, 32'h0000_0000, 1'b1);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_SEED, 32'hffff_ffff, 1'b0);
        add_req(CMD_DRAW, 32'hffff_ffff, 1'b0);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_SEED, DEFAULT_SEED, 1'b0);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        add_req(CMD_DRAW, 32'h0000_0000, 1'b0);
        // back-to-back reseeds
        add_req(CMD_SEED, 32'h8000_0000, 1'b0);
        add_req(CMD_SEED, 32'h7fff_ffff, 1'b0);
        add_req(CMD_SEED, 32'h0000_0001, 1'b0);
        add_req(CMD_DRAW, 32'h5555_5555, 1'b0);
        add_req(CMD_DRAW, 32'haaaa_aaaa, 1'b0);
        // long run wraps the state array once
        add_req(CMD_SEED, $urandom, 1'b1);
        for (int i = 0; i < 700; i++)
        begin
            add_req(CMD_DRAW, $urandom, 1'b0);
        end
        for (int i = 0; i < 300; i++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                add_req(CMD_SEED, $urandom, 1'($urandom_range(0, 1)));
            end
            else
            begin
                add_req(CMD_DRAW, $urandom, 1'b0);
            end
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (failures == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/mtg_pkg.sv
sv/mtg_state_ram.sv
sv/mtg_out_buf.sv
sv/mtg_core.sv
sv/mersenne_twister_generator.sv
sim/tb_top.sv
